>>> rtl/blsw_pkg.sv
// shared types, constants and duty mapping for the backlight sleep / touch wake block
package blsw_pkg;

    // request type codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_TOUCH  = 2'd1;
    localparam logic [1:0] REQ_BRIGHT = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH   = 2'd1;

    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned IDLE_W    = 26;

    // duty codes (inverted pwm)
    localparam logic [7:0] DUTY_BRIGHT = 8'd30;
    localparam logic [7:0] DUTY_DIM    = 8'd240;
    localparam logic [7:0] DUTY_OFF    = 8'd247;

    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [9:0] MS_PER_S = 10'd1000;

    // pct*210/100 = (pct*21)/10, divide by ten via reciprocal 6554/2^16
    localparam logic [11:0] DUTY_STEP_NUM = 12'd21;
    localparam logic [24:0] RECIP_TEN     = 25'd6554;

    // reset values
    localparam logic [6:0]           BRIGHT_RESET     = 7'd80;
    localparam logic [IDLE_W-1:0]    TIMEOUT_MS_RESET = 26'd30000;
    localparam logic [IDLE_W-1:0]    IDLE_MAX         = {IDLE_W{1'b1}};

    // configuration seen by the core
    typedef struct packed {
        logic [IDLE_W-1:0] timeout_ms;
        logic              touch_en;
        logic              clear_idle;
    } t_cfg;

    // non-coordinate part of an input beat
    typedef struct packed {
        logic [1:0] req_type;
        logic       touched;
        logic [7:0] brightness_pct;
    } t_req;

    // brightness percent to inverted duty
    function automatic logic [7:0] duty_of(logic [6:0] pct);
        logic [11:0] scaled;
        logic [24:0] prod;
        logic [7:0]  drop;
        scaled = 12'(pct) * DUTY_STEP_NUM;
        prod   = 25'(scaled) * RECIP_TEN;
        drop   = prod[23:16];
        if (pct >= PCT_FULL) begin
            return DUTY_BRIGHT;
        end else if (pct == 7'd0) begin
            return DUTY_OFF;
        end else begin
            return DUTY_DIM - drop;
        end
    endfunction

endpackage

>>> rtl/blsw_cfg.sv
// configuration registers: screen timeout (kept in ms) and touch enable
module blsw_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [blsw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [blsw_pkg::TIMEOUT_W-1:0]     i_cfg_data,
    output logic                               o_cfg_ready,
    output blsw_pkg::t_cfg                     o_cfg
);

    logic [blsw_pkg::IDLE_W-1:0] r_timeout_ms;
    logic                        r_touch_en;
    logic                        wr_timeout;
    logic                        wr_touch;

    assign o_cfg_ready = 1'b1;
    assign wr_timeout  = i_cfg_valid && (i_cfg_index == blsw_pkg::CFG_TIMEOUT);
    assign wr_touch    = i_cfg_valid && (i_cfg_index == blsw_pkg::CFG_TOUCH);

    // timeout converted to ms once, at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= blsw_pkg::TIMEOUT_MS_RESET;
            r_touch_en   <= 1'b1;
        end else begin
            if (wr_timeout) begin
                r_timeout_ms <= 26'(i_cfg_data) * 26'(blsw_pkg::MS_PER_S);
            end
            if (wr_touch) begin
                r_touch_en <= i_cfg_data[0];
            end
        end
    end

    assign o_cfg.timeout_ms = r_timeout_ms;
    assign o_cfg.touch_en   = r_touch_en;
    assign o_cfg.clear_idle = wr_timeout;

endmodule

>>> rtl/blsw_core.sv
// controller state and single-pass item evaluation into the result register
module blsw_core #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  blsw_pkg::t_req         i_req,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  blsw_pkg::t_cfg         i_cfg,
    output logic                   o_pwm_write,
    output logic [7:0]             o_pwm_duty,
    output logic                   o_report_valid,
    output logic                   o_report_pressed,
    output logic [COORD_WIDTH-1:0] o_point_x,
    output logic [COORD_WIDTH-1:0] o_point_y,
    output logic                   o_blank_request,
    output logic                   o_redraw_request,
    output logic                   o_backlight_is_on,
    output logic                   o_is_asleep
);

    // state
    logic [6:0]                  r_level,   n_level;
    logic                        r_bl,      n_bl;
    logic                        r_asleep,  n_asleep;
    logic                        r_swallow, n_swallow;
    logic [blsw_pkg::IDLE_W-1:0] r_idle,    n_idle;

    // result register
    logic                   r_pwm_write,  n_pwm_write;
    logic [7:0]             r_pwm_duty,   n_pwm_duty;
    logic                   r_rep_valid,  n_rep_valid;
    logic                   r_rep_press,  n_rep_press;
    logic [COORD_WIDTH-1:0] r_px,         n_px;
    logic [COORD_WIDTH-1:0] r_py,         n_py;
    logic                   r_blank,      n_blank;
    logic                   r_redraw,     n_redraw;

    logic [blsw_pkg::IDLE_W-1:0] idle_inc;
    logic [6:0]                  pct_clamped;
    logic [6:0]                  duty_src;
    logic [7:0]                  duty_val;

    // saturating idle count and clamped brightness
    assign idle_inc    = (r_idle == blsw_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;
    assign pct_clamped = (i_req.brightness_pct > 8'(blsw_pkg::PCT_FULL)) ?
                         blsw_pkg::PCT_FULL : i_req.brightness_pct[6:0];

    // one shared duty mapping: new request or stored level on wake
    assign duty_src = (i_req.req_type == blsw_pkg::REQ_BRIGHT) ? pct_clamped : r_level;
    assign duty_val = blsw_pkg::duty_of(duty_src);

    // next state and result
    always_comb begin
        n_level     = r_level;
        n_bl        = r_bl;
        n_asleep    = r_asleep;
        n_swallow   = r_swallow;
        n_idle      = r_idle;
        n_pwm_write = 1'b0;
        n_pwm_duty  = 8'd0;
        n_rep_valid = 1'b0;
        n_rep_press = 1'b0;
        n_px        = '0;
        n_py        = '0;
        n_blank     = 1'b0;
        n_redraw    = 1'b0;
        case (i_req.req_type)
            blsw_pkg::REQ_TICK: begin
                n_idle = idle_inc;
                if (!r_asleep && (i_cfg.timeout_ms != '0) && r_bl &&
                    (idle_inc > i_cfg.timeout_ms)) begin
                    n_pwm_write = 1'b1;
                    n_pwm_duty  = blsw_pkg::DUTY_OFF;
                    n_bl        = 1'b0;
                    n_asleep    = 1'b1;
                    n_blank     = 1'b1;
                end
            end
            blsw_pkg::REQ_TOUCH: begin
                if (r_asleep) begin
                    // wake on press, swallow until release
                    if (i_cfg.touch_en && i_req.touched) begin
                        n_pwm_write = 1'b1;
                        n_pwm_duty  = duty_val;
                        n_bl        = 1'b1;
                        n_asleep    = 1'b0;
                        n_swallow   = 1'b1;
                        n_idle      = '0;
                        n_redraw    = 1'b1;
                    end
                end else begin
                    n_rep_valid = 1'b1;
                    if (i_cfg.touch_en) begin
                        if (i_req.touched) begin
                            n_idle = '0;
                            if (!r_swallow) begin
                                n_rep_press = 1'b1;
                                n_px        = i_x;
                                n_py        = i_y;
                            end
                        end else begin
                            n_swallow = 1'b0;
                        end
                    end
                end
            end
            blsw_pkg::REQ_BRIGHT: begin
                n_level     = pct_clamped;
                n_pwm_write = 1'b1;
                if (pct_clamped == 7'd0) begin
                    n_pwm_duty = blsw_pkg::DUTY_OFF;
                    n_bl       = 1'b0;
                end else begin
                    n_pwm_duty = duty_val;
                    n_bl       = 1'b1;
                    n_asleep   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // state update, timeout write clears idle time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= blsw_pkg::BRIGHT_RESET;
            r_bl      <= 1'b1;
            r_asleep  <= 1'b0;
            r_swallow <= 1'b0;
            r_idle    <= '0;
        end else begin
            if (i_fire) begin
                r_level   <= n_level;
                r_bl      <= n_bl;
                r_asleep  <= n_asleep;
                r_swallow <= n_swallow;
                r_idle    <= n_idle;
            end
            if (i_cfg.clear_idle) begin
                r_idle <= '0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pwm_write <= n_pwm_write;
            r_pwm_duty  <= n_pwm_duty;
            r_rep_valid <= n_rep_valid;
            r_rep_press <= n_rep_press;
            r_px        <= n_px;
            r_py        <= n_py;
            r_blank     <= n_blank;
            r_redraw    <= n_redraw;
        end
    end

    // flags after the item travel with the result
    logic r_out_bl, r_out_asleep;
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_out_bl     <= n_bl;
            r_out_asleep <= n_asleep;
        end
    end

    assign o_pwm_write       = r_pwm_write;
    assign o_pwm_duty        = r_pwm_duty;
    assign o_report_valid    = r_rep_valid;
    assign o_report_pressed  = r_rep_press;
    assign o_point_x         = r_px;
    assign o_point_y         = r_py;
    assign o_blank_request   = r_blank;
    assign o_redraw_request  = r_redraw;
    assign o_backlight_is_on = r_out_bl;
    assign o_is_asleep       = r_out_asleep;

endmodule

>>> rtl/backlight_sleep_touch_wake.sv
// top level: input register, result handshake and configuration port
// One beat is accepted per clock while o_in_stall is low, and each beat gives exactly one
// result beat through the input register, then the result register. The whole update of
// brightness, sleep, swallow and idle state plus the duty mapping is done in one pass between
// those registers, so the sustained rate is one item per cycle whenever the output side does not
// stall. The configuration port is always ready; write it only while no beat is in flight.
// Writing the timeout register clears the idle time, and a timeout of zero disables sleep.
module backlight_sleep_touch_wake #(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_req_type,
    input  logic                               i_touched,
    input  logic [COORD_WIDTH-1:0]             i_touch_x,
    input  logic [COORD_WIDTH-1:0]             i_touch_y,
    input  logic [7:0]                         i_brightness_pct,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pwm_write,
    output logic [7:0]                         o_pwm_duty,
    output logic                               o_report_valid,
    output logic                               o_report_pressed,
    output logic [COORD_WIDTH-1:0]             o_point_x,
    output logic [COORD_WIDTH-1:0]             o_point_y,
    output logic                               o_blank_request,
    output logic                               o_redraw_request,
    output logic                               o_backlight_is_on,
    output logic                               o_is_asleep,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [blsw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [blsw_pkg::TIMEOUT_W-1:0]     i_cfg_data
);

    logic                   r_s1_valid;
    blsw_pkg::t_req         r_s1_req;
    logic [COORD_WIDTH-1:0] r_s1_x;
    logic [COORD_WIDTH-1:0] r_s1_y;
    logic                   r_out_valid;
    logic                   advance;
    logic                   fire;
    logic                   in_accept;
    blsw_pkg::t_cfg         cfg;

    // pipeline control
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !advance);
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req.req_type       <= i_req_type;
            r_s1_req.touched        <= i_touched;
            r_s1_req.brightness_pct <= i_brightness_pct;
            r_s1_x                  <= i_touch_x;
            r_s1_y                  <= i_touch_y;
        end
    end

    assign o_out_valid = r_out_valid;

    blsw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    blsw_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_req             (r_s1_req),
        .i_x               (r_s1_x),
        .i_y               (r_s1_y),
        .i_cfg             (cfg),
        .o_pwm_write       (o_pwm_write),
        .o_pwm_duty        (o_pwm_duty),
        .o_report_valid    (o_report_valid),
        .o_report_pressed  (o_report_pressed),
        .o_point_x         (o_point_x),
        .o_point_y         (o_point_y),
        .o_blank_request   (o_blank_request),
        .o_redraw_request  (o_redraw_request),
        .o_backlight_is_on (o_backlight_is_on),
        .o_is_asleep       (o_is_asleep)
    );

    // entering sleep always writes the off code and drops the backlight
    a_blank_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_blank_request |->
            o_pwm_write && (o_pwm_duty == blsw_pkg::DUTY_OFF) && o_is_asleep &&
            !o_backlight_is_on)
        else $error("blank request without sleep and off duty");

    // a wake writes a duty, turns the backlight on and gives no report
    a_redraw_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_redraw_request |->
            o_pwm_write && !o_is_asleep && o_backlight_is_on && !o_report_valid &&
            !o_blank_request)
        else $error("redraw request with inconsistent flags");

    // pressed reports only come from an awake block
    a_press_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_pressed |-> o_report_valid && !o_is_asleep &&
            !o_pwm_write)
        else $error("pressed report while asleep or with duty write");

    // a held input beat stays in the input register
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1_req))
        else $error("input register lost a stalled beat");

endmodule

>>> test/backlight_sleep_touch_wake_tb.sv
// self-checking testbench for the backlight sleep / touch wake controller
module backlight_sleep_touch_wake_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_W = 10;

    // request code the block does not use
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // register indexes beyond the register list
    localparam logic [blsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [blsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // duty mapping and timing constants
    localparam logic [7:0]    DUTY_FULL   = 8'd30;
    localparam int unsigned   DUTY_BASE   = 240;
    localparam logic [7:0]    DUTY_BLACK  = 8'd247;
    localparam logic [6:0]    PCT_MAX     = 7'd100;
    localparam int unsigned   MS_PER_SEC  = 1000;
    localparam logic [25:0]   IDLE_TOP    = {26{1'b1}};
    localparam int unsigned   HOLD_CYCLES = 80;
    localparam int            RANDOM_GOAL = 1950;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               touched;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic [7:0]         pct;
    } t_ctrl_beat;

    typedef struct packed {
        logic               pwm_write;
        logic [7:0]         pwm_duty;
        logic               report_valid;
        logic               report_pressed;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               blank_req;
        logic               redraw_req;
        logic               backlight_on;
        logic               asleep;
    } t_panel_update;

    typedef struct packed {
        t_ctrl_beat    beat;
        logic          typed;
        t_panel_update want;
    } t_directed_row;

    localparam t_panel_update PREDICTED = '0;

    // directed rows, typed results where they are obvious
    localparam t_directed_row DIRECTED_ROWS [20] = '{
        '{'{blsw_pkg::REQ_TICK, 0, 0, 0, 0}, 1, '{0, 0, 1'b0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_TOUCH, 1, 1023, 1023, 0}, 1, '{0, 0, 1, 1, 1023, 1023, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_TOUCH, 1, 0, 0, 255}, 1, '{0, 0, 1, 1, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_TOUCH, 0, 1023, 1023, 0}, 1, '{0, 0, 1, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 100}, 1, '{1, DUTY_FULL, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_BRIGHT, 1, 1023, 1023, 255}, 1, '{1, DUTY_FULL, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 0}, 1, '{1, DUTY_BLACK, 0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{blsw_pkg::REQ_TICK, 1, 1023, 1023, 255}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{blsw_pkg::REQ_TOUCH, 1, 512, 256, 0}, 1, '{0, 0, 1, 1, 512, 256, 0, 0, 0, 0}},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 1}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 99}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 50}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 101}, 1, '{1, DUTY_FULL, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 128}, 1, '{1, DUTY_FULL, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{REQ_UNUSED, 1, 1023, 1023, 255}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{REQ_UNUSED, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0}},
        '{'{blsw_pkg::REQ_TOUCH, 1, 682, 341, 0}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_BRIGHT, 0, 0, 0, 7}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_TOUCH, 0, 0, 0, 0}, 0, PREDICTED},
        '{'{blsw_pkg::REQ_TICK, 0, 0, 0, 0}, 0, PREDICTED}
    };

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic [1:0]                           i_req_type;
    logic                                 i_touched;
    logic [COORD_W-1:0]                   i_touch_x;
    logic [COORD_W-1:0]                   i_touch_y;
    logic [7:0]                           i_brightness_pct;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic                                 o_pwm_write;
    logic [7:0]                           o_pwm_duty;
    logic                                 o_report_valid;
    logic                                 o_report_pressed;
    logic [COORD_W-1:0]                   o_point_x;
    logic [COORD_W-1:0]                   o_point_y;
    logic                                 o_blank_request;
    logic                                 o_redraw_request;
    logic                                 o_backlight_is_on;
    logic                                 o_is_asleep;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [blsw_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [blsw_pkg::TIMEOUT_W-1:0]       i_cfg_data;

    // predicted controller state and register copies
    logic [6:0]                     level_now;
    logic                           backlight_now;
    logic                           asleep_now;
    logic                           swallow_now;
    logic [25:0]                    idle_count;
    logic [blsw_pkg::TIMEOUT_W-1:0] cfg_timeout_s;
    logic                           cfg_touch_en;

    t_panel_update panel_updates_due [$];
    int            mismatch_count = 0;
    int            touch_wakes    = 0;
    int            random_sent    = 0;
    int            burst_left     = 0;
    int            hold_off_asks  = 0;
    int            hold_off_done  = 0;

    backlight_sleep_touch_wake #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_touched        (i_touched),
        .i_touch_x        (i_touch_x),
        .i_touch_y        (i_touch_y),
        .i_brightness_pct (i_brightness_pct),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pwm_write      (o_pwm_write),
        .o_pwm_duty       (o_pwm_duty),
        .o_report_valid   (o_report_valid),
        .o_report_pressed (o_report_pressed),
        .o_point_x        (o_point_x),
        .o_point_y        (o_point_y),
        .o_blank_request  (o_blank_request),
        .o_redraw_request (o_redraw_request),
        .o_backlight_is_on(o_backlight_is_on),
        .o_is_asleep      (o_is_asleep),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // end the run if it hangs
    initial begin
        #15ms;
        $display("end of test: mismatches");
        $finish;
    end

    // brightness level to inverted duty
    function automatic logic [7:0] duty_for(input logic [6:0] lvl);
        if (lvl >= PCT_MAX) begin
            return DUTY_FULL;
        end
        if (lvl == 7'd0) begin
            return DUTY_BLACK;
        end
        return 8'(DUTY_BASE - (32'(lvl) * (DUTY_BASE - 32'(DUTY_FULL))) / 100);
    endfunction

    // advance the predicted state by one beat and return the panel update it causes
    function automatic t_panel_update next_panel_update(input t_ctrl_beat b);
        t_panel_update u;
        logic [6:0]    lvl;
        u = '0;
        case (b.req_type)
            blsw_pkg::REQ_TICK: begin
                if (idle_count != IDLE_TOP) begin
                    idle_count = idle_count + 26'd1;
                end
                if (!asleep_now && cfg_timeout_s != '0 && backlight_now &&
                        32'(idle_count) > 32'(cfg_timeout_s) * MS_PER_SEC) begin
                    u.pwm_write   = 1'b1;
                    u.pwm_duty    = DUTY_BLACK;
                    u.blank_req   = 1'b1;
                    backlight_now = 1'b0;
                    asleep_now    = 1'b1;
                end
            end
            blsw_pkg::REQ_TOUCH: begin
                if (asleep_now) begin
                    // wake on a press, restore duty even when it is the off code
                    if (cfg_touch_en && b.touched) begin
                        u.pwm_write   = 1'b1;
                        u.pwm_duty    = duty_for(level_now);
                        u.redraw_req  = 1'b1;
                        backlight_now = 1'b1;
                        asleep_now    = 1'b0;
                        swallow_now   = 1'b1;
                        idle_count    = '0;
                        touch_wakes++;
                    end
                end else begin
                    u.report_valid = 1'b1;
                    if (cfg_touch_en) begin
                        if (b.touched) begin
                            idle_count = '0;
                            if (!swallow_now) begin
                                u.report_pressed = 1'b1;
                                u.point_x        = b.touch_x;
                                u.point_y        = b.touch_y;
                            end
                        end else begin
                            swallow_now = 1'b0;
                        end
                    end
                end
            end
            blsw_pkg::REQ_BRIGHT: begin
                lvl         = (b.pct > 8'(PCT_MAX)) ? PCT_MAX : b.pct[6:0];
                level_now   = lvl;
                u.pwm_write = 1'b1;
                if (lvl == 7'd0) begin
                    u.pwm_duty    = DUTY_BLACK;
                    backlight_now = 1'b0;
                end else begin
                    u.pwm_duty    = duty_for(lvl);
                    backlight_now = 1'b1;
                    asleep_now    = 1'b0;
                end
            end
            default: begin
            end
        endcase
        u.backlight_on = backlight_now;
        u.asleep       = asleep_now;
        return u;
    endfunction

    // brightness request spread over zero, full, clamped and in-range values
    function automatic logic [7:0] draw_pct();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd100;
            2: return 8'($urandom_range(255, 101));
            default: return 8'($urandom_range(99, 1));
        endcase
    endfunction

    // next random beat, steered toward sleep when asked
    function automatic t_ctrl_beat draw_beat(input bit steer);
        t_ctrl_beat  b;
        int unsigned roll;
        bit          quiet;
        b.touch_x  = COORD_W'($urandom);
        b.touch_y  = COORD_W'($urandom);
        b.touched  = 1'($urandom_range(1));
        b.pct      = draw_pct();
        b.req_type = 2'($urandom_range(3));
        roll       = $urandom_range(99);
        quiet      = steer && !asleep_now && cfg_touch_en &&
                     32'(idle_count) <= 32'(cfg_timeout_s) * MS_PER_SEC;
        if (asleep_now) begin
            // mostly presses and brightness while asleep
            if (roll < 25) begin
                b.req_type = blsw_pkg::REQ_TICK;
            end else if (roll < 70) begin
                b.req_type = blsw_pkg::REQ_TOUCH;
                b.touched  = ($urandom_range(99) < 65);
            end else if (roll < 95) begin
                b.req_type = blsw_pkg::REQ_BRIGHT;
            end else begin
                b.req_type = REQ_UNUSED;
            end
        end else if (quiet) begin
            // let the idle time build: no presses once it has grown
            if (roll < 84) begin
                b.req_type = blsw_pkg::REQ_TICK;
            end else if (roll < 92) begin
                b.req_type = blsw_pkg::REQ_TOUCH;
                b.touched  = (idle_count < 26'd20) ? 1'($urandom_range(1)) : 1'b0;
            end else if (roll < 98) begin
                b.req_type = blsw_pkg::REQ_BRIGHT;
                if (!backlight_now) begin
                    b.pct = 8'($urandom_range(255, 1));
                end
            end else begin
                b.req_type = REQ_UNUSED;
            end
        end else begin
            if (roll < 45) begin
                b.req_type = blsw_pkg::REQ_TICK;
            end else if (roll < 80) begin
                b.req_type = blsw_pkg::REQ_TOUCH;
            end else if (roll < 95) begin
                b.req_type = blsw_pkg::REQ_BRIGHT;
            end else begin
                b.req_type = REQ_UNUSED;
            end
        end
        return b;
    endfunction

    // offer one beat after a random gap, predict it once accepted
    task automatic send_beat(input t_ctrl_beat b, input logic typed, input t_panel_update want);
        int unsigned gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(39) == 0) begin
            burst_left = $urandom_range(60, 20);
            gap        = 0;
        end else begin
            gap = $urandom_range(1) ? 0 : $urandom_range(18);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= b.req_type;
        i_touched        <= b.touched;
        i_touch_x        <= b.touch_x;
        i_touch_y        <= b.touch_y;
        i_brightness_pct <= b.pct;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = typed ? want : next_panel_update(b);
        if (typed) begin
            void'(next_panel_update(b));
        end
        panel_updates_due.push_back(want);
    endtask

    // random beats until the goals are met or the cap is hit
    task automatic run_random(input bit steer, input int min_beats, input int wake_goal,
                              input bit end_asleep, input int cap);
        int n;
        n = 0;
        while (n < cap && !(n >= min_beats && touch_wakes >= wake_goal &&
                            (!end_asleep || asleep_now))) begin
            send_beat(draw_beat(steer), 1'b0, PREDICTED);
            n++;
            random_sent++;
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (panel_updates_due.size() != 0) @(posedge i_clk);
    endtask

    // one register write, valid dropped after the last of a batch
    task automatic write_reg(input logic [blsw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [blsw_pkg::TIMEOUT_W-1:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            blsw_pkg::CFG_TIMEOUT: begin
                cfg_timeout_s = data;
                idle_count    = '0;
            end
            blsw_pkg::CFG_TOUCH: cfg_touch_en = data[0];
            default: begin
            end
        endcase
        if (last) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    // field compare with report
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_panel_update want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (panel_updates_due.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = panel_updates_due.pop_front();
                check_field("pwm_write", 16'(want.pwm_write), 16'(o_pwm_write));
                check_field("pwm_duty", 16'(want.pwm_duty), 16'(o_pwm_duty));
                check_field("report_valid", 16'(want.report_valid), 16'(o_report_valid));
                check_field("report_pressed", 16'(want.report_pressed), 16'(o_report_pressed));
                check_field("point_x", 16'(want.point_x), 16'(o_point_x));
                check_field("point_y", 16'(want.point_y), 16'(o_point_y));
                check_field("blank_request", 16'(want.blank_req), 16'(o_blank_request));
                check_field("redraw_request", 16'(want.redraw_req), 16'(o_redraw_request));
                check_field("backlight_is_on", 16'(want.backlight_on), 16'(o_backlight_is_on));
                check_field("is_asleep", 16'(want.asleep), 16'(o_is_asleep));
            end
        end
    end

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int unsigned wait_cycles;
        int          calm_left;
        calm_left = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_asks != hold_off_done) begin
                wait_cycles   = HOLD_CYCLES;
                hold_off_done = hold_off_asks;
            end else if (calm_left > 0) begin
                wait_cycles = 0;
                calm_left--;
            end else if ($urandom_range(39) == 0) begin
                calm_left   = $urandom_range(60, 20);
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(1) ? 0 : $urandom_range(18);
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // reset, directed rows, then random phases across register settings
    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_req_type       <= blsw_pkg::REQ_TICK;
        i_touched        <= 1'b0;
        i_touch_x        <= '0;
        i_touch_y        <= '0;
        i_brightness_pct <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= blsw_pkg::CFG_TIMEOUT;
        i_cfg_data       <= '0;
        level_now     = 7'd80;
        backlight_now = 1'b1;
        asleep_now    = 1'b0;
        swallow_now   = 1'b0;
        idle_count    = '0;
        cfg_timeout_s = 16'd30;
        cfg_touch_en  = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            send_beat(DIRECTED_ROWS[k].beat, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        end
        drain();

        // shortest timeout, spare indexes must be ignored; one sleep and a touch wake
        write_reg(blsw_pkg::CFG_TIMEOUT, 16'd1, 1'b0);
        write_reg(CFG_SPARE_A, 16'($urandom), 1'b0);
        write_reg(CFG_SPARE_B, 16'($urandom), 1'b1);
        run_random(1'b1, 0, 1, 1'b0, 1500);
        drain();

        // touch disabled, upper data bits set
        write_reg(blsw_pkg::CFG_TOUCH, 16'hFFFE, 1'b1);
        run_random(1'b0, 150, 0, 1'b0, 150);
        drain();

        // longest timeout, touch back on; receiver holds off while beats keep coming
        write_reg(blsw_pkg::CFG_TIMEOUT, 16'hFFFF, 1'b0);
        write_reg(blsw_pkg::CFG_TOUCH, 16'h0001, 1'b1);
        hold_off_asks++;
        burst_left = 12;
        run_random(1'b0, 150, 0, 1'b0, 150);
        drain();

        // sleep disabled
        write_reg(blsw_pkg::CFG_TIMEOUT, 16'h0000, 1'b1);
        run_random(1'b0, 150, 0, 1'b0, 150);
        drain();

        // shortest timeout again for the rest of the beats
        write_reg(blsw_pkg::CFG_TIMEOUT, 16'd1, 1'b1);
        run_random(1'b1, (random_sent < RANDOM_GOAL) ? RANDOM_GOAL - random_sent : 0, 0,
                   1'b0, RANDOM_GOAL);
        drain();

        // catch any stray result after the last one
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/blsw_pkg.sv
rtl/blsw_cfg.sv
rtl/blsw_core.sv
rtl/backlight_sleep_touch_wake.sv
test/backlight_sleep_touch_wake_tb.sv
